// ===== rtl/kyber_coefficient_compress_pack_macros.svh =====
// Assertion macros used by the compress-and-pack top level.
`ifndef KYBER_COEFFICIENT_COMPRESS_PACK_MACROS_SVH
`define KYBER_COEFFICIENT_COMPRESS_PACK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KCCP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KCCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KCCP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define KCCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/kccp_pkg.sv =====
// Types, constants and mode decode for the coefficient compress-and-pack block.
package kccp_pkg;
    localparam int NUM_LANES = 8;
    localparam int COEF_W    = 12;
    localparam int Q_W       = 11;
    localparam int PACK_W    = 88;
    localparam int LOW_W     = 64;
    localparam int HIGH_W    = 24;
    localparam int BITS_W    = 4;

    localparam logic [BITS_W-1:0] D_W1  = 4'd1;
    localparam logic [BITS_W-1:0] D_W4  = 4'd4;
    localparam logic [BITS_W-1:0] D_W5  = 4'd5;
    localparam logic [BITS_W-1:0] D_W10 = 4'd10;
    localparam logic [BITS_W-1:0] D_W11 = 4'd11;
    localparam logic [BITS_W-1:0] D_RESET = D_W4;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 12'sd1664;
    localparam logic signed [COEF_W-1:0] COEF_MIN = -12'sd1664;

    typedef logic [Q_W-1:0] t_qval;
    typedef t_qval [NUM_LANES-1:0] t_lane_q;

    typedef struct packed {
        logic [BITS_W-1:0] bits;
        logic              err;
    } t_mode;

    function automatic t_mode decode_mode(input logic [BITS_W-1:0] d);
        t_mode m;
        m.bits = d;
        m.err  = !((d == D_W1) || (d == D_W4) || (d == D_W5) ||
                   (d == D_W10) || (d == D_W11));
        return m;
    endfunction
endpackage

// ===== rtl/kyber_coefficient_compress_pack.sv =====
// Top level: eight compression lanes, pack/merge stage, handshake and config register.
// An accepted input passes through the lane register, then the output register, before result valid.
// Throughput: one item of eight coefficients per cycle while the output is not stalled; the eight lanes each do one
// constant-multiply quotient per item and the merge stage packs them once stage 2 is empty or draining.
// Reset (synchronous, active low): pipeline empty, compress_bits = 4; config always ready.
module kyber_coefficient_compress_pack (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [kccp_pkg::COEF_W-1:0]   i_coef_0,
    input  logic signed [kccp_pkg::COEF_W-1:0]   i_coef_1,
    input  logic signed [kccp_pkg::COEF_W-1:0]   i_coef_2,
    input  logic signed [kccp_pkg::COEF_W-1:0]   i_coef_3,
    input  logic signed [kccp_pkg::COEF_W-1:0]   i_coef_4,
    input  logic signed [kccp_pkg::COEF_W-1:0]   i_coef_5,
    input  logic signed [kccp_pkg::COEF_W-1:0]   i_coef_6,
    input  logic signed [kccp_pkg::COEF_W-1:0]   i_coef_7,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [kccp_pkg::LOW_W-1:0]           o_packed_low,
    output logic [kccp_pkg::HIGH_W-1:0]          o_packed_high,
    output logic [kccp_pkg::BITS_W-1:0]          o_byte_count,
    output logic                                 o_mode_error,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kccp_pkg::BITS_W-1:0]          i_compress_bits
);
    import kccp_pkg::*;
`include "kyber_coefficient_compress_pack_macros.svh"

    logic [BITS_W-1:0]        r_compress_bits;
    logic [BITS_W-1:0]        n_compress_bits;
    logic                     r_v1;
    logic                     n_v1;
    logic                     r_v2;
    logic                     n_v2;
    logic                     in_acc;
    logic                     out_acc;
    logic                     s2_load;
    logic                     out_zero;
    t_mode                    mode;
    t_lane_q                  lane_q;
    logic signed [COEF_W-1:0] coef [NUM_LANES];

    assign coef[0] = i_coef_0;
    assign coef[1] = i_coef_1;
    assign coef[2] = i_coef_2;
    assign coef[3] = i_coef_3;
    assign coef[4] = i_coef_4;
    assign coef[5] = i_coef_5;
    assign coef[6] = i_coef_6;
    assign coef[7] = i_coef_7;

    assign mode = decode_mode(r_compress_bits);

    // stage 1 moves on when stage 2 is empty or draining this cycle
    assign out_acc = r_v2 && i_ready;
    assign s2_load = r_v1 && (!r_v2 || i_ready);
    assign o_ready = !r_v1 || s2_load;
    assign in_acc  = i_valid && o_ready;
    assign o_valid = r_v2;
    assign o_cfg_ready = 1'b1;

    assign out_zero = (o_packed_low == '0) && (o_packed_high == '0) && (o_byte_count == '0);

    always_comb begin
        n_v1 = r_v1;
        if (in_acc) begin
            n_v1 = 1'b1;
        end else if (s2_load) begin
            n_v1 = 1'b0;
        end
        n_v2 = r_v2;
        if (s2_load) begin
            n_v2 = 1'b1;
        end else if (out_acc) begin
            n_v2 = 1'b0;
        end
        n_compress_bits = i_cfg_valid ? i_compress_bits : r_compress_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1            <= 1'b0;
            r_v2            <= 1'b0;
            r_compress_bits <= D_RESET;
        end else begin
            r_v1            <= n_v1;
            r_v2            <= n_v2;
            r_compress_bits <= n_compress_bits;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        kccp_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (in_acc),
            .i_mode (mode),
            .i_coef (coef[g]),
            .o_q    (lane_q[g])
        );
    end

    kccp_merge u_merge (
        .i_clk         (i_clk),
        .i_en          (s2_load),
        .i_mode        (mode),
        .i_q           (lane_q),
        .o_packed_low  (o_packed_low),
        .o_packed_high (o_packed_high),
        .o_byte_count  (o_byte_count),
        .o_mode_error  (o_mode_error)
    );

    `KCCP_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_mode_error, out_zero)
    `KCCP_ASSERT_IMPL(a_ok_count, i_clk, i_rst_n, o_valid && !o_mode_error, o_byte_count != '0)
    `KCCP_ASSERT_NEXT(a_advance, i_clk, i_rst_n, r_v1 && !r_v2, o_valid)
    `KCCP_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, !o_ready, r_v1 && r_v2 && !i_ready)
endmodule

// ===== rtl/kccp_lane.sv =====
// One compression lane: clamp a coefficient and form its D-bit quotient.
module kccp_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  kccp_pkg::t_mode                      i_mode,
    input  logic signed [kccp_pkg::COEF_W-1:0]   i_coef,
    output kccp_pkg::t_qval                      o_q
);
    import kccp_pkg::*;

    logic signed [COEF_W-1:0] a;
    logic signed [21:0]       p315;
    logic signed [21:0]       p315_rnd;
    logic signed [5:0]        h1;
    logic signed [5:0]        h4;
    logic signed [5:0]        t1;
    logic signed [5:0]        t4;
    logic signed [27:0]       p_neg;
    logic signed [16:0]       p20;
    logic signed [15:0]       s;
    logic signed [16:0]       s10;
    logic signed [16:0]       s11;
    t_qval                    n_q;
    t_qval                    r_q;

    always_comb begin
        if (i_coef > COEF_MAX) begin
            a = COEF_MAX;
        end else if (i_coef < COEF_MIN) begin
            a = COEF_MIN;
        end else begin
            a = i_coef;
        end
    end

    // a*630 >> 16 equals a*315 >> 15, so one product serves D = 1, 4, 5
    assign p315     = 22'(a) * 22'sd315;
    assign h1       = 6'(p315 >>> 16);
    assign h4       = 6'(p315 >>> 15);
    assign t1       = h1 + 6'sd4;
    assign t4       = h4 + 6'sd1;
    assign p315_rnd = p315 + 22'sd16384;

    // Barrett step for D = 10, 11; the sum wraps at 16 bits
    assign p_neg = 28'(a) * -28'sd20553;
    assign p20   = 17'(a) * 17'sd20;
    assign s     = 16'(p_neg >>> 16) + p20[15:0];
    assign s10   = 17'(s) + 17'sd32;
    assign s11   = 17'(s) + 17'sd16;

    always_comb begin
        case (i_mode.bits)
            D_W1:    n_q = {10'd0, t1[3]};
            D_W4:    n_q = {7'd0, t4[4:1]};
            D_W5:    n_q = {6'd0, p315_rnd[19:15]};
            D_W10:   n_q = {1'b0, s10[15:6]};
            D_W11:   n_q = s11[15:5];
            default: n_q = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

// ===== rtl/kccp_merge.sv =====
// Merge stage: packs eight lane quotients LSB first into the output register.
module kccp_merge (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  kccp_pkg::t_mode               i_mode,
    input  kccp_pkg::t_lane_q             i_q,
    output logic [kccp_pkg::LOW_W-1:0]    o_packed_low,
    output logic [kccp_pkg::HIGH_W-1:0]   o_packed_high,
    output logic [kccp_pkg::BITS_W-1:0]   o_byte_count,
    output logic                          o_mode_error
);
    import kccp_pkg::*;

    logic [PACK_W-1:0] n_packed;
    logic [PACK_W-1:0] r_packed;
    logic [BITS_W-1:0] n_byte_count;
    logic [BITS_W-1:0] r_byte_count;
    logic              r_mode_error;

    always_comb begin
        n_packed = '0;
        case (i_mode.bits)
            D_W1: begin
                for (int k = 0; k < NUM_LANES; k++) n_packed[k*1 +: 1] = i_q[k][0:0];
            end
            D_W4: begin
                for (int k = 0; k < NUM_LANES; k++) n_packed[k*4 +: 4] = i_q[k][3:0];
            end
            D_W5: begin
                for (int k = 0; k < NUM_LANES; k++) n_packed[k*5 +: 5] = i_q[k][4:0];
            end
            D_W10: begin
                for (int k = 0; k < NUM_LANES; k++) n_packed[k*10 +: 10] = i_q[k][9:0];
            end
            D_W11: begin
                for (int k = 0; k < NUM_LANES; k++) n_packed[k*11 +: 11] = i_q[k][10:0];
            end
            default: n_packed = '0;
        endcase
        n_byte_count = i_mode.err ? '0 : i_mode.bits;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_packed     <= n_packed;
            r_byte_count <= n_byte_count;
            r_mode_error <= i_mode.err;
        end
    end

    assign o_packed_low  = r_packed[LOW_W-1:0];
    assign o_packed_high = r_packed[PACK_W-1:LOW_W];
    assign o_byte_count  = r_byte_count;
    assign o_mode_error  = r_mode_error;
endmodule
